### src/assert_macros.svh
// Assertion macros for the ring interference pixel block.
// Users include this file and provide clk_i and rst_ni in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property at every clock edge outside reset.
`define RIP_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check that a condition in one cycle implies another in the next cycle.
`define RIP_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### src/rip_pkg.sv
// Shared widths, codes and types for the ring interference pixel block.
// No dependencies.
`timescale 1ns / 1ps

package rip_pkg;

  // Port field widths
  localparam int COL_W  = 10;
  localparam int ROW_W  = 9;
  localparam int OFFX_W = 10;
  localparam int OFFY_W = 9;
  localparam int PIX_W  = 8;
  localparam int CFG_W  = 10;

  // Signed distance to a ring centre and its magnitude
  localparam int DIFF_W = 12;
  localparam int MAG_W  = 11;

  // Squared radius, integer root and partial remainder
  localparam int RAD_W  = 2 * MAG_W;
  localparam int ROOT_W = MAG_W;
  localparam int REM_W  = ROOT_W + 2;

  // Reciprocal multiply for division of the root by the ring width (up to 8 bits)
  localparam int RECIP_SHIFT = ROOT_W + 8;
  localparam int RECIP_W     = RECIP_SHIFT + 1;

  // Ring datapath stages: magnitude, square, sum, one per root bit, quotient
  localparam int RING_STG = ROOT_W + 4;

  // Output intensities
  localparam logic [PIX_W-1:0] PIX_ON  = 8'hFF;
  localparam logic [PIX_W-1:0] PIX_OFF = 8'h00;

  // Configuration register indexes
  localparam logic CFG_OFFSET_X = 1'b0;
  localparam logic CFG_OFFSET_Y = 1'b1;

  // State handed from one root cell to the next
  typedef struct packed {
    logic [RAD_W-1:0]  rad;
    logic [REM_W-1:0]  rem;
    logic [ROOT_W-1:0] root;
  } root_step_t;

endpackage

### src/rip_root_cell.sv
// One digit cell of the integer square root chain: resolves one root bit.
// Depends on rip_pkg.
`timescale 1ns / 1ps

module rip_root_cell import rip_pkg::*; (
  input  logic       clk_i,
  input  logic       en_i,
  input  root_step_t step_i,
  output root_step_t step_o
);

  logic [REM_W-1:0] rem_sh;
  logic [REM_W-1:0] trial;
  root_step_t       step_d;
  root_step_t       step_q;

  // Bring down the next radicand bit pair and try a one bit
  assign rem_sh = {step_i.rem[REM_W-3:0], step_i.rad[RAD_W-1 -: 2]};
  assign trial  = {step_i.root, 2'b01};

  always_comb begin
    step_d.rad = {step_i.rad[RAD_W-3:0], 2'b00};
    if (rem_sh >= trial) begin
      step_d.rem  = rem_sh - trial;
      step_d.root = {step_i.root[ROOT_W-2:0], 1'b1};
    end else begin
      step_d.rem  = rem_sh;
      step_d.root = {step_i.root[ROOT_W-2:0], 1'b0};
    end
  end

  // Hand the partial result to the next cell
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      step_q <= step_d;
    end
  end

  assign step_o = step_q;

endmodule

### src/rip_ring.sv
// One ring set: distance to the centre, squared radius, root cell chain and
// ring parity. Depends on rip_pkg and rip_root_cell.
`timescale 1ns / 1ps

module rip_ring import rip_pkg::*; #(
  parameter int RING_WIDTH   = 15,
  parameter int FRAME_WIDTH  = 640,
  parameter int FRAME_HEIGHT = 480
) (
  input  logic                clk_i,
  input  logic [RING_STG-1:0] en_i,
  input  logic [COL_W-1:0]    column_i,
  input  logic [ROW_W-1:0]    row_i,
  input  logic [OFFX_W-1:0]   offset_x_i,
  input  logic [OFFY_W-1:0]   offset_y_i,
  output logic                ring_bit_o
);

  localparam logic [DIFF_W-1:0] CX = DIFF_W'(FRAME_WIDTH / 2 - 1);
  localparam logic [DIFF_W-1:0] CY = DIFF_W'(FRAME_HEIGHT / 2 - 1);
  localparam int unsigned RECIP_INT =
    ((32'd1 << RECIP_SHIFT) + RING_WIDTH - 1) / RING_WIDTH;
  localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP_INT);
  localparam int CELL0 = 3;

  logic [DIFF_W-1:0]         dx;
  logic [DIFF_W-1:0]         dy;
  logic [DIFF_W-1:0]         dx_abs;
  logic [DIFF_W-1:0]         dy_abs;
  logic [MAG_W-1:0]          mag_x_q;
  logic [MAG_W-1:0]          mag_y_q;
  logic [RAD_W-1:0]          sq_x_q;
  logic [RAD_W-1:0]          sq_y_q;
  logic [RAD_W-1:0]          sum;
  root_step_t                chain [ROOT_W+1];
  root_step_t                head_d;
  root_step_t                head_q;
  logic [ROOT_W+RECIP_W-1:0] quot;
  logic                      ring_bit_q;

  // Signed offsets from the centre, wrapped to the datapath width
  assign dx = {{(DIFF_W-COL_W){1'b0}}, column_i}
            + {{(DIFF_W-OFFX_W){offset_x_i[OFFX_W-1]}}, offset_x_i} - CX;
  assign dy = {{(DIFF_W-ROW_W){1'b0}}, row_i}
            + {{(DIFF_W-OFFY_W){offset_y_i[OFFY_W-1]}}, offset_y_i} - CY;
  assign dx_abs = dx[DIFF_W-1] ? (~dx + 1'b1) : dx;
  assign dy_abs = dy[DIFF_W-1] ? (~dy + 1'b1) : dy;

  // Stage 0: hold magnitudes
  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      mag_x_q <= dx_abs[MAG_W-1:0];
      mag_y_q <= dy_abs[MAG_W-1:0];
    end
  end

  // Stage 1: square each axis
  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      sq_x_q <= mag_x_q * mag_x_q;
      sq_y_q <= mag_y_q * mag_y_q;
    end
  end

  // Stage 2: sum of squares seeds the root chain (always fits the radicand width)
  assign sum         = sq_x_q + sq_y_q;
  assign head_d.rad  = sum;
  assign head_d.rem  = '0;
  assign head_d.root = '0;

  always_ff @(posedge clk_i) begin
    if (en_i[2]) begin
      head_q <= head_d;
    end
  end

  assign chain[0] = head_q;

  // Root chain, one bit per cell from the top
  for (genvar i = 0; i < ROOT_W; i++) begin : g_cell
    rip_root_cell u_cell (
      .clk_i  (clk_i),
      .en_i   (en_i[CELL0+i]),
      .step_i (chain[i]),
      .step_o (chain[i+1])
    );
  end

  // Last stage: quotient by ring width, even quotient sets the ring bit
  assign quot = chain[ROOT_W].root * RECIP;

  always_ff @(posedge clk_i) begin
    if (en_i[RING_STG-1]) begin
      ring_bit_q <= ~quot[RECIP_SHIFT];
    end
  end

  assign ring_bit_o = ring_bit_q;

endmodule

### src/ring_interference_pixel.sv
// Ring interference pixel generator: top level with handshake, offset
// registers and two ring datapaths. Depends on rip_pkg, rip_ring, assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Each transferred pixel position yields one intensity, passing through one
// stage each for distance, square, sum of squares and division by the ring
// width, eleven root cells (one per root bit) and the output register. A new
// position may be transferred every cycle unless the output stalls with every
// stage full. When the output stalls, the pipeline squeezes out empty stages
// first, so positions keep coming in until every stage is full. Offsets are
// written through the configuration port, index 0 for the horizontal and 1
// for the vertical one; write them only while no pixel is in flight.
module ring_interference_pixel import rip_pkg::*; #(
  parameter int RING_WIDTH   = 15,
  parameter int FRAME_WIDTH  = 640,
  parameter int FRAME_HEIGHT = 480
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [COL_W-1:0]  column_i,
  input  logic [ROW_W-1:0]  row_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [PIX_W-1:0]  pixel_value_o,
  input  logic              cfg_we_i,
  input  logic              cfg_index_i,
  input  logic [CFG_W-1:0]  cfg_data_i
);

  localparam int LAT = RING_STG + 1;

  logic [OFFX_W-1:0] offset_x_q;
  logic [OFFY_W-1:0] offset_y_q;
  logic [LAT-1:0]    valid_q;
  logic [LAT-1:0]    valid_d;
  logic [LAT-1:0]    adv;
  logic              ring_a;
  logic              ring_b;
  logic [PIX_W-1:0]  pixel_q;

  // Offset registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      offset_x_q <= '0;
      offset_y_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_OFFSET_X: offset_x_q <= cfg_data_i[OFFX_W-1:0];
        CFG_OFFSET_Y: offset_y_q <= cfg_data_i[OFFY_W-1:0];
        default: ;
      endcase
    end
  end

  // Advance a stage when it is empty or the stage after it advances
  always_comb begin
    adv[LAT-1] = !valid_q[LAT-1] || out_ready_i;
    for (int k = LAT - 2; k >= 0; k--) begin
      adv[k] = !valid_q[k] || adv[k+1];
    end
  end

  always_comb begin
    valid_d[0] = adv[0] ? in_valid_i : valid_q[0];
    for (int k = 1; k < LAT; k++) begin
      valid_d[k] = adv[k] ? valid_q[k-1] : valid_q[k];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Ring set around the frame centre
  rip_ring #(
    .RING_WIDTH   (RING_WIDTH),
    .FRAME_WIDTH  (FRAME_WIDTH),
    .FRAME_HEIGHT (FRAME_HEIGHT)
  ) u_ring_a (
    .clk_i      (clk_i),
    .en_i       (adv[RING_STG-1:0]),
    .column_i   (column_i),
    .row_i      (row_i),
    .offset_x_i ('0),
    .offset_y_i ('0),
    .ring_bit_o (ring_a)
  );

  // Ring set shifted by the configured offsets
  rip_ring #(
    .RING_WIDTH   (RING_WIDTH),
    .FRAME_WIDTH  (FRAME_WIDTH),
    .FRAME_HEIGHT (FRAME_HEIGHT)
  ) u_ring_b (
    .clk_i      (clk_i),
    .en_i       (adv[RING_STG-1:0]),
    .column_i   (column_i),
    .row_i      (row_i),
    .offset_x_i (offset_x_q),
    .offset_y_i (offset_y_q),
    .ring_bit_o (ring_b)
  );

  // Output register: lit only where both ring bits are set
  always_ff @(posedge clk_i) begin
    if (adv[LAT-1]) begin
      pixel_q <= (ring_a && ring_b) ? PIX_ON : PIX_OFF;
    end
  end

  assign in_ready_o    = adv[0];
  assign out_valid_o   = valid_q[LAT-1];
  assign pixel_value_o = pixel_q;

  `RIP_ASSERT(a_pix_levels, !out_valid_o || pixel_value_o == PIX_ON || pixel_value_o == PIX_OFF, "pixel value is neither on nor off")
  `RIP_ASSERT_NEXT(a_accept_fills, in_valid_i && in_ready_o, valid_q[0], "transferred position lost at first stage")
  `RIP_ASSERT(a_no_block, !out_ready_i || in_ready_o, "input blocked while output drains")

endmodule
